// ===== hdl/cqt_pkg.sv =====
// ----------------------------------------------------------------------------
// cqt_pkg
// Shared types, codes and per-byte tokenizer functions for the CSV tokenizer.
// ----------------------------------------------------------------------------
package cqt_pkg;

   localparam int          QUEUE_DEPTH   = 4;
   localparam int          MAX_RES       = 6;
   localparam int          RES_CNT_W     = 3;

   localparam logic [7:0]  DELIM_RESET   = 8'd44;
   localparam logic [7:0]  ENCL_RESET    = 8'd34;
   localparam logic [7:0]  CH_CR         = 8'h0D;
   localparam logic [7:0]  CH_LF         = 8'h0A;
   localparam logic [7:0]  BOM_0         = 8'hEF;
   localparam logic [7:0]  BOM_1         = 8'hBB;
   localparam logic [7:0]  BOM_2         = 8'hBF;
   localparam logic [1:0]  BOM_LEN       = 2'd3;

   localparam logic [1:0]  KIND_DATA       = 2'd0;
   localparam logic [1:0]  KIND_FIELD_END  = 2'd1;
   localparam logic [1:0]  KIND_RECORD_END = 2'd2;

   localparam logic        CSR_DELIM     = 1'b0;
   localparam logic        CSR_ENCL      = 1'b1;

   typedef enum logic [2:0] {
      Q_OUTSIDE = 3'b001,
      Q_INSIDE  = 3'b010,
      Q_AFTER   = 3'b100
   } quote_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] field_byte;
   } res_type;

   // all results caused by one item
   typedef struct packed {
      res_type [MAX_RES-1:0] res;
      logic [RES_CNT_W-1:0]  cnt;
   } bundle_type;

   typedef struct packed {
      quote_type  quote;
      logic       held;
      bundle_type bnd;
   } work_type;

   function automatic logic [7:0] bom_byte(logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = BOM_0;
         2'd1:    r = BOM_1;
         default: r = BOM_2;
      endcase
      return r;
   endfunction

   function automatic work_type emit(work_type w, logic [1:0] k, logic [7:0] b);
      work_type r;
      r = w;
      r.bnd.res[w.bnd.cnt].kind       = k;
      r.bnd.res[w.bnd.cnt].field_byte = b;
      r.bnd.cnt = w.bnd.cnt + 1'b1;
      return r;
   endfunction

   // a CR is held back until we know it is not the tail of a record
   function automatic work_type push_data(work_type w, logic [7:0] b);
      work_type r;
      r = w;
      if (r.held) r = emit(r, KIND_DATA, CH_CR);
      if (b == CH_CR) begin
         r.held = 1'b1;
      end else begin
         r.held = 1'b0;
         r = emit(r, KIND_DATA, b);
      end
      return r;
   endfunction

   function automatic work_type end_field(work_type w);
      work_type r;
      r = w;
      if (r.held) r = emit(r, KIND_DATA, CH_CR);
      r.held = 1'b0;
      r = emit(r, KIND_FIELD_END, 8'd0);
      return r;
   endfunction

   function automatic work_type end_record(work_type w);
      work_type r;
      r = w;
      r.held  = 1'b0;
      r.quote = Q_OUTSIDE;
      r = emit(r, KIND_RECORD_END, 8'd0);
      return r;
   endfunction

   // one byte of line content, never a newline
   function automatic work_type line_byte(work_type w, logic [7:0] b,
                                          logic [7:0] delim, logic [7:0] encl);
      work_type r;
      r = w;
      if (b == delim && r.quote != Q_INSIDE) begin
         r.quote = Q_OUTSIDE;
         r = end_field(r);
      end else if (b == encl) begin
         if (r.quote == Q_AFTER) begin
            r.quote = Q_INSIDE;
            r = push_data(r, b);
         end else begin
            r.quote = (r.quote == Q_OUTSIDE) ? Q_INSIDE : Q_AFTER;
         end
      end else begin
         if (r.quote == Q_AFTER) r.quote = Q_OUTSIDE;
         r = push_data(r, b);
      end
      return r;
   endfunction

endpackage

// ===== hdl/cqt_front.sv =====
// ----------------------------------------------------------------------------
// cqt_front
// Accepts raw bytes, tracks quote/CR/BOM state, builds one result bundle per item.
// ----------------------------------------------------------------------------
module cqt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_stream,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata,
   output logic                bnd_push,
   output cqt_pkg::bundle_type bnd_out
);

   cqt_pkg::quote_type quote_ff, quote_in;
   logic       held_ff, held_in;
   logic       at_start_ff, at_start_in;
   logic [1:0] bom_cnt_ff, bom_cnt_in;
   logic       line_has_ff, line_has_in;
   logic [7:0] delim_ff, encl_ff;

   cqt_pkg::work_type w;

   always_comb begin
      w.quote     = quote_ff;
      w.held      = held_ff;
      w.bnd       = '0;
      at_start_in = at_start_ff;
      bom_cnt_in  = bom_cnt_ff;
      line_has_in = line_has_ff;
      quote_in    = quote_ff;
      held_in     = held_ff;

      if (end_of_stream) begin
         if (line_has_ff) begin
            if (at_start_ff && bom_cnt_ff >= 2'd1)
               w = cqt_pkg::line_byte(w, cqt_pkg::BOM_0, delim_ff, encl_ff);
            if (at_start_ff && bom_cnt_ff >= 2'd2)
               w = cqt_pkg::line_byte(w, cqt_pkg::BOM_1, delim_ff, encl_ff);
            if (w.quote != cqt_pkg::Q_INSIDE) w = cqt_pkg::end_record(w);
         end
         quote_in    = cqt_pkg::Q_OUTSIDE;
         held_in     = 1'b0;
         at_start_in = 1'b1;
         bom_cnt_in  = 2'd0;
         line_has_in = 1'b0;
      end else if (data_byte == cqt_pkg::CH_LF) begin
         if (at_start_ff && bom_cnt_ff >= 2'd1)
            w = cqt_pkg::line_byte(w, cqt_pkg::BOM_0, delim_ff, encl_ff);
         if (at_start_ff && bom_cnt_ff >= 2'd2)
            w = cqt_pkg::line_byte(w, cqt_pkg::BOM_1, delim_ff, encl_ff);
         if (w.quote == cqt_pkg::Q_INSIDE) w = cqt_pkg::push_data(w, cqt_pkg::CH_LF);
         else                              w = cqt_pkg::end_record(w);
         quote_in    = w.quote;
         held_in     = w.held;
         at_start_in = 1'b0;
         bom_cnt_in  = 2'd0;
         line_has_in = 1'b0;
      end else begin
         line_has_in = 1'b1;
         if (at_start_ff && bom_cnt_ff < cqt_pkg::BOM_LEN &&
             data_byte == cqt_pkg::bom_byte(bom_cnt_ff)) begin
            // full match drops the mark
            if (bom_cnt_ff == cqt_pkg::BOM_LEN - 2'd1) begin
               at_start_in = 1'b0;
               bom_cnt_in  = 2'd0;
            end else begin
               bom_cnt_in  = bom_cnt_ff + 2'd1;
            end
         end else begin
            // partial match is replayed ahead of this byte
            if (at_start_ff && bom_cnt_ff >= 2'd1)
               w = cqt_pkg::line_byte(w, cqt_pkg::BOM_0, delim_ff, encl_ff);
            if (at_start_ff && bom_cnt_ff >= 2'd2)
               w = cqt_pkg::line_byte(w, cqt_pkg::BOM_1, delim_ff, encl_ff);
            w = cqt_pkg::line_byte(w, data_byte, delim_ff, encl_ff);
            at_start_in = 1'b0;
            bom_cnt_in  = 2'd0;
         end
         quote_in = w.quote;
         held_in  = w.held;
      end
   end

   assign bnd_out  = w.bnd;
   assign bnd_push = accept && (w.bnd.cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff    <= cqt_pkg::Q_OUTSIDE;
         held_ff     <= 1'b0;
         at_start_ff <= 1'b1;
         bom_cnt_ff  <= 2'd0;
         line_has_ff <= 1'b0;
         delim_ff    <= cqt_pkg::DELIM_RESET;
         encl_ff     <= cqt_pkg::ENCL_RESET;
      end else begin
         if (accept) begin
            quote_ff    <= quote_in;
            held_ff     <= held_in;
            at_start_ff <= at_start_in;
            bom_cnt_ff  <= bom_cnt_in;
            line_has_ff <= line_has_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               cqt_pkg::CSR_DELIM: delim_ff <= csr_wdata;
               cqt_pkg::CSR_ENCL:  encl_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== hdl/cqt_queue.sv =====
// ----------------------------------------------------------------------------
// cqt_queue
// Small FIFO of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module cqt_queue #(
   parameter int Depth = cqt_pkg::QUEUE_DEPTH  // 2 or more
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cqt_pkg::bundle_type din,
   input  logic                pop,
   output cqt_pkg::bundle_type dout,
   output logic                full,
   output logic                empty
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cqt_pkg::bundle_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= din;
   end

endmodule

// ===== hdl/cqt_back.sv =====
// ----------------------------------------------------------------------------
// cqt_back
// Walks the head bundle one result per pop and releases it after the last one.
// ----------------------------------------------------------------------------
module cqt_back (
   input  logic                clock,
   input  logic                reset,
   input  cqt_pkg::bundle_type head,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic                pop,
   output logic                empty,
   output logic [1:0]          kind,
   output logic [7:0]          field_byte,
   output logic                last_of_run
);

   logic [cqt_pkg::RES_CNT_W-1:0] pos_ff, pos_in;
   logic take;

   assign empty       = q_empty;
   assign kind        = head.res[pos_ff].kind;
   assign field_byte  = head.res[pos_ff].field_byte;
   assign last_of_run = (pos_ff == head.cnt - 1'b1);
   assign take        = pop && !q_empty;
   assign q_pop       = take && last_of_run;

   always_comb begin
      pos_in = pos_ff;
      if (take) pos_in = last_of_run ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hdl/csv_quoted_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_quoted_field_tokenizer
// A result is registered in the bundle FIFO and reaches rsp after earlier ones.
// Throughput: one item per cycle while full is low, pop is held and items give
// at most one result each; an item with n results needs n pops, absorbed by a
// QueueDepth FIFO. Reset: synchronous; tracker state cleared, delimiter 44,
// enclosure 34, FIFO empty. Configuration takes effect the cycle after the write.
// ----------------------------------------------------------------------------
module csv_quoted_field_tokenizer #(
   parameter int QueueDepth = cqt_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_field_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   cqt_pkg::bundle_type bnd_in, bnd_head;
   logic bnd_push, q_pop, q_empty, accept;

   assign accept = push && !full;

   cqt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .bnd_push      (bnd_push),
      .bnd_out       (bnd_in)
   );

   cqt_queue #(.Depth(QueueDepth)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (bnd_push),
      .din   (bnd_in),
      .pop   (q_pop),
      .dout  (bnd_head),
      .full  (full),
      .empty (q_empty)
   );

   cqt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (bnd_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .kind        (rsp_kind),
      .field_byte  (rsp_field_byte),
      .last_of_run (rsp_last_of_run)
   );

endmodule
